/* rtl/core/icmp_ht_pkg.sv */
// ----------------------------------------------------------------------------
// icmp_ht_pkg
// Shared types and constants for the ICMP header translator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package icmp_ht_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TUNNEL_MTU   = 2'd0,
    CFG_HDR_DIFF     = 2'd1,
    CFG_MIN_MTU_V4   = 2'd2,
    CFG_MIN_MTU_V6   = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] RST_TUNNEL_MTU = 16'd1500;
  localparam logic [7:0]  RST_HDR_DIFF   = 8'd20;
  localparam logic [15:0] RST_MIN_MTU_V4 = 16'd68;
  localparam logic [15:0] RST_MIN_MTU_V6 = 16'd1280;

  // Direction
  localparam logic DIR_V4_TO_V6 = 1'b0;
  localparam logic DIR_V6_TO_V4 = 1'b1;

  // ICMPv4 types
  localparam logic [7:0] ICMP4_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] ICMP4_DEST_UNREACH = 8'd3;
  localparam logic [7:0] ICMP4_ECHO_REQ     = 8'd8;
  localparam logic [7:0] ICMP4_TIME_EXCEED  = 8'd11;

  // ICMPv4 destination unreachable codes
  localparam logic [7:0] UNR4_NET          = 8'd0;
  localparam logic [7:0] UNR4_HOST         = 8'd1;
  localparam logic [7:0] UNR4_PROTO        = 8'd2;
  localparam logic [7:0] UNR4_PORT         = 8'd3;
  localparam logic [7:0] UNR4_FRAG_NEEDED  = 8'd4;
  localparam logic [7:0] UNR4_SRC_ROUTE    = 8'd5;
  localparam logic [7:0] UNR4_NET_UNKNOWN  = 8'd6;
  localparam logic [7:0] UNR4_HOST_UNKNOWN = 8'd7;
  localparam logic [7:0] UNR4_SRC_ISOLATED = 8'd8;
  localparam logic [7:0] UNR4_NET_PROHIB   = 8'd9;
  localparam logic [7:0] UNR4_HOST_PROHIB  = 8'd10;
  localparam logic [7:0] UNR4_NET_TOS      = 8'd11;
  localparam logic [7:0] UNR4_HOST_TOS     = 8'd12;
  localparam logic [7:0] UNR4_ADMIN_PROHIB = 8'd13;
  localparam logic [7:0] UNR4_PREC_CUTOFF  = 8'd15;

  // ICMPv6 types
  localparam logic [7:0] ICMP6_DEST_UNREACH = 8'd1;
  localparam logic [7:0] ICMP6_PKT_TOO_BIG  = 8'd2;
  localparam logic [7:0] ICMP6_TIME_EXCEED  = 8'd3;
  localparam logic [7:0] ICMP6_BAD_PARAM    = 8'd4;
  localparam logic [7:0] ICMP6_ECHO_REQ     = 8'd128;
  localparam logic [7:0] ICMP6_ECHO_RSP     = 8'd129;

  // ICMPv6 codes
  localparam logic [7:0] UNR6_NO_ROUTE     = 8'd0;
  localparam logic [7:0] UNR6_ADMIN_PROHIB = 8'd1;
  localparam logic [7:0] UNR6_BEYOND_SCOPE = 8'd2;
  localparam logic [7:0] UNR6_ADDR         = 8'd3;
  localparam logic [7:0] UNR6_PORT         = 8'd4;
  localparam logic [7:0] CODE_ZERO         = 8'd0;
  localparam logic [7:0] PARAM6_NEXT_HDR   = 8'd1;
  localparam logic [7:0] PTR_NEXT_HDR      = 8'd6;

  // Lengths
  localparam logic [15:0] V4_MIN_ERR_LEN = 16'd20;
  localparam logic [15:0] V6_HDR_LEN     = 16'd40;
  localparam logic [15:0] QUOTE6_MAX     = 16'd1192;
  localparam logic [15:0] QUOTE4_MAX     = 16'd528;
  localparam logic [15:0] FRAG_HDR_LEN   = 16'd8;
  localparam logic [7:0]  NH_FRAGMENT    = 8'd44;

  // RFC 1191 plateau table, largest first
  localparam int unsigned PLATEAU_CNT = 10;
  localparam logic [15:0] PLATEAU [PLATEAU_CNT] = '{
    16'd65535, 16'd32000, 16'd17914, 16'd8166, 16'd4352,
    16'd2002,  16'd1492,  16'd1006,  16'd508,  16'd296
  };

  typedef enum logic [1:0] {
    REST_COPY,
    REST_ZERO,
    REST_PTR,
    REST_MTU
  } rest_sel_t;

  typedef struct packed {
    logic [15:0] tunnel_mtu;
    logic [7:0]  header_size_diff;
    logic [15:0] min_mtu_v4;
    logic [15:0] min_mtu_v6;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [31:0] rest_word;
    logic [15:0] outer_total_len;
    logic [15:0] body_len;
    logic [3:0]  inner_ihl;
    logic [7:0]  inner_next_header;
  } hdr_in_t;

  typedef struct packed {
    logic        op;
    logic        drop;
    logic        is_error;
    logic        frag;
    logic [7:0]  out_type;
    logic [7:0]  out_code;
    rest_sel_t   rest_sel;
    logic [31:0] rest_word;
    logic [15:0] plateau_mtu;
    logic [15:0] quote_raw;
  } cls_t;

  typedef struct packed {
    logic        op;
    logic        drop;
    logic        is_error;
    logic [7:0]  out_type;
    logic [7:0]  out_code;
    rest_sel_t   rest_sel;
    logic [31:0] rest_word;
    logic [15:0] mtu;
    logic [10:0] quote_len;
  } res_t;

  typedef struct packed {
    logic        drop;
    logic [7:0]  out_type;
    logic [7:0]  out_code;
    logic [31:0] out_rest_word;
    logic        is_error;
    logic [10:0] quoted_payload_len;
  } hdr_out_t;

endpackage

`default_nettype wire

/* rtl/core/icmp_ht_classify.sv */
// ----------------------------------------------------------------------------
// icmp_ht_classify
// Stage 1: map type and code, check lengths, pick the plateau MTU estimate.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_ht_classify (
  input  wire                   clk,
  input  wire                   rst_n,
  input  icmp_ht_pkg::cfg_t     cfg,
  input  wire                   up_valid,
  output logic                  up_ready,
  input  icmp_ht_pkg::hdr_in_t  up_data,
  output logic                  dn_valid,
  input  wire                   dn_ready,
  output icmp_ht_pkg::cls_t     dn_data
);

  icmp_ht_pkg::cls_t cls_nxt;
  icmp_ht_pkg::cls_t cls_r;
  logic              valid_r;
  logic              echo;
  logic              map_ok;
  logic              len_bad;
  logic [15:0]       ihl_bytes;
  logic [15:0]       plateau;

  assign up_ready  = !valid_r || dn_ready;
  assign dn_valid  = valid_r;
  assign dn_data   = cls_r;
  assign ihl_bytes = {10'd0, up_data.inner_ihl, 2'b00};

  always_comb begin
    plateau = cfg.min_mtu_v4;
    for (int i = int'(icmp_ht_pkg::PLATEAU_CNT) - 1; i >= 0; i--) begin
      if (up_data.outer_total_len > icmp_ht_pkg::PLATEAU[i]) begin
        plateau = icmp_ht_pkg::PLATEAU[i];
      end
    end
  end

  always_comb begin
    cls_nxt             = '0;
    cls_nxt.op          = up_data.op;
    cls_nxt.rest_word   = up_data.rest_word;
    cls_nxt.frag        = (up_data.inner_next_header == icmp_ht_pkg::NH_FRAGMENT);
    cls_nxt.plateau_mtu = plateau;
    cls_nxt.rest_sel    = icmp_ht_pkg::REST_ZERO;
    echo                = 1'b0;
    map_ok              = 1'b1;
    if (up_data.op == icmp_ht_pkg::DIR_V4_TO_V6) begin
      len_bad = (up_data.body_len < icmp_ht_pkg::V4_MIN_ERR_LEN) ||
                (ihl_bytes > up_data.body_len);
      cls_nxt.quote_raw = up_data.body_len - ihl_bytes;
      unique case (up_data.msg_type)
        icmp_ht_pkg::ICMP4_ECHO_REPLY: begin
          echo             = 1'b1;
          cls_nxt.out_type = icmp_ht_pkg::ICMP6_ECHO_RSP;
        end
        icmp_ht_pkg::ICMP4_ECHO_REQ: begin
          echo             = 1'b1;
          cls_nxt.out_type = icmp_ht_pkg::ICMP6_ECHO_REQ;
        end
        icmp_ht_pkg::ICMP4_DEST_UNREACH: begin
          unique case (up_data.msg_code)
            icmp_ht_pkg::UNR4_NET, icmp_ht_pkg::UNR4_HOST,
            icmp_ht_pkg::UNR4_SRC_ROUTE, icmp_ht_pkg::UNR4_NET_UNKNOWN,
            icmp_ht_pkg::UNR4_HOST_UNKNOWN, icmp_ht_pkg::UNR4_SRC_ISOLATED,
            icmp_ht_pkg::UNR4_NET_TOS, icmp_ht_pkg::UNR4_HOST_TOS: begin
              cls_nxt.out_type = icmp_ht_pkg::ICMP6_DEST_UNREACH;
              cls_nxt.out_code = icmp_ht_pkg::UNR6_NO_ROUTE;
            end
            icmp_ht_pkg::UNR4_PROTO: begin
              cls_nxt.out_type = icmp_ht_pkg::ICMP6_BAD_PARAM;
              cls_nxt.out_code = icmp_ht_pkg::PARAM6_NEXT_HDR;
              cls_nxt.rest_sel = icmp_ht_pkg::REST_PTR;
            end
            icmp_ht_pkg::UNR4_PORT: begin
              cls_nxt.out_type = icmp_ht_pkg::ICMP6_DEST_UNREACH;
              cls_nxt.out_code = icmp_ht_pkg::UNR6_PORT;
            end
            icmp_ht_pkg::UNR4_FRAG_NEEDED: begin
              cls_nxt.out_type = icmp_ht_pkg::ICMP6_PKT_TOO_BIG;
              cls_nxt.out_code = icmp_ht_pkg::CODE_ZERO;
              cls_nxt.rest_sel = icmp_ht_pkg::REST_MTU;
            end
            icmp_ht_pkg::UNR4_NET_PROHIB, icmp_ht_pkg::UNR4_HOST_PROHIB,
            icmp_ht_pkg::UNR4_ADMIN_PROHIB, icmp_ht_pkg::UNR4_PREC_CUTOFF: begin
              cls_nxt.out_type = icmp_ht_pkg::ICMP6_DEST_UNREACH;
              cls_nxt.out_code = icmp_ht_pkg::UNR6_ADMIN_PROHIB;
            end
            default: map_ok = 1'b0;
          endcase
        end
        icmp_ht_pkg::ICMP4_TIME_EXCEED: begin
          cls_nxt.out_type = icmp_ht_pkg::ICMP6_TIME_EXCEED;
          cls_nxt.out_code = up_data.msg_code;
        end
        default: map_ok = 1'b0;
      endcase
    end else begin
      len_bad           = (up_data.body_len < icmp_ht_pkg::V6_HDR_LEN);
      cls_nxt.quote_raw = up_data.body_len - icmp_ht_pkg::V6_HDR_LEN;
      unique case (up_data.msg_type)
        icmp_ht_pkg::ICMP6_ECHO_REQ: begin
          echo             = 1'b1;
          cls_nxt.out_type = icmp_ht_pkg::ICMP4_ECHO_REQ;
        end
        icmp_ht_pkg::ICMP6_ECHO_RSP: begin
          echo             = 1'b1;
          cls_nxt.out_type = icmp_ht_pkg::ICMP4_ECHO_REPLY;
        end
        icmp_ht_pkg::ICMP6_DEST_UNREACH: begin
          cls_nxt.out_type = icmp_ht_pkg::ICMP4_DEST_UNREACH;
          unique case (up_data.msg_code)
            icmp_ht_pkg::UNR6_NO_ROUTE, icmp_ht_pkg::UNR6_BEYOND_SCOPE:
              cls_nxt.out_code = icmp_ht_pkg::UNR4_HOST;
            icmp_ht_pkg::UNR6_ADMIN_PROHIB:
              cls_nxt.out_code = icmp_ht_pkg::UNR4_HOST_PROHIB;
            icmp_ht_pkg::UNR6_PORT:
              cls_nxt.out_code = icmp_ht_pkg::UNR4_PORT;
            default: map_ok = 1'b0;
          endcase
        end
        icmp_ht_pkg::ICMP6_PKT_TOO_BIG: begin
          cls_nxt.out_type = icmp_ht_pkg::ICMP4_DEST_UNREACH;
          cls_nxt.out_code = icmp_ht_pkg::UNR4_FRAG_NEEDED;
          cls_nxt.rest_sel = icmp_ht_pkg::REST_MTU;
        end
        icmp_ht_pkg::ICMP6_TIME_EXCEED: begin
          cls_nxt.out_type = icmp_ht_pkg::ICMP4_TIME_EXCEED;
          cls_nxt.out_code = up_data.msg_code;
        end
        icmp_ht_pkg::ICMP6_BAD_PARAM: begin
          cls_nxt.out_type = icmp_ht_pkg::ICMP4_DEST_UNREACH;
          cls_nxt.out_code = icmp_ht_pkg::UNR4_PROTO;
          map_ok           = (up_data.msg_code == icmp_ht_pkg::PARAM6_NEXT_HDR);
        end
        default: map_ok = 1'b0;
      endcase
    end
    if (echo) begin
      cls_nxt.rest_sel = icmp_ht_pkg::REST_COPY;
      cls_nxt.out_code = icmp_ht_pkg::CODE_ZERO;
    end
    cls_nxt.is_error = !echo;
    cls_nxt.drop     = !echo && (!map_ok || len_bad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/icmp_ht_resolve.sv */
// ----------------------------------------------------------------------------
// icmp_ht_resolve
// Stage 2: choose the MTU source and truncate the quoted payload length.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_ht_resolve (
  input  wire                clk,
  input  wire                rst_n,
  input  icmp_ht_pkg::cfg_t  cfg,
  input  wire                up_valid,
  output logic               up_ready,
  input  icmp_ht_pkg::cls_t  up_data,
  output logic               dn_valid,
  input  wire                dn_ready,
  output icmp_ht_pkg::res_t  dn_data
);

  icmp_ht_pkg::res_t res_nxt;
  icmp_ht_pkg::res_t res_r;
  logic              valid_r;
  logic [15:0]       q_clip;
  logic              frag_short;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = res_r;

  always_comb begin
    res_nxt.op        = up_data.op;
    res_nxt.is_error  = up_data.is_error;
    res_nxt.out_type  = up_data.out_type;
    res_nxt.out_code  = up_data.out_code;
    res_nxt.rest_sel  = up_data.rest_sel;
    res_nxt.rest_word = up_data.rest_word;
    frag_short        = 1'b0;
    if (up_data.op == icmp_ht_pkg::DIR_V4_TO_V6) begin
      res_nxt.mtu = (up_data.rest_word[15:0] < cfg.min_mtu_v4) ?
                    up_data.plateau_mtu : up_data.rest_word[15:0];
      q_clip      = (up_data.quote_raw > icmp_ht_pkg::QUOTE6_MAX) ?
                    icmp_ht_pkg::QUOTE6_MAX : up_data.quote_raw;
    end else begin
      res_nxt.mtu = (up_data.rest_word > {16'd0, cfg.tunnel_mtu}) ?
                    cfg.tunnel_mtu : up_data.rest_word[15:0];
      q_clip      = (up_data.quote_raw > icmp_ht_pkg::QUOTE4_MAX) ?
                    icmp_ht_pkg::QUOTE4_MAX : up_data.quote_raw;
      if (up_data.frag) begin
        frag_short = (q_clip < icmp_ht_pkg::FRAG_HDR_LEN);
        q_clip     = q_clip - icmp_ht_pkg::FRAG_HDR_LEN;
      end
    end
    res_nxt.quote_len = q_clip[10:0];
    res_nxt.drop      = up_data.drop || (up_data.is_error && frag_short);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/icmp_ht_emit.sv */
// ----------------------------------------------------------------------------
// icmp_ht_emit
// Stage 3: clamp and adjust the MTU, build the rest word, zero dropped results.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_ht_emit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  icmp_ht_pkg::cfg_t     cfg,
  input  wire                   up_valid,
  output logic                  up_ready,
  input  icmp_ht_pkg::res_t     up_data,
  output logic                  dn_valid,
  input  wire                   dn_ready,
  output icmp_ht_pkg::hdr_out_t dn_data
);

  icmp_ht_pkg::hdr_out_t out_nxt;
  icmp_ht_pkg::hdr_out_t out_r;
  logic                  valid_r;
  logic [15:0]           mtu_floor;
  logic [16:0]           mtu_up;
  logic [15:0]           mtu_dn;
  logic [15:0]           diff16;
  logic [31:0]           mtu_word;
  logic [31:0]           rest;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = out_r;
  assign diff16   = {8'd0, cfg.header_size_diff};

  always_comb begin
    mtu_floor = (up_data.mtu < cfg.min_mtu_v6) ? cfg.min_mtu_v6 : up_data.mtu;
    mtu_up    = {1'b0, mtu_floor} + {1'b0, diff16};
    mtu_dn    = (up_data.mtu > diff16) ? (up_data.mtu - diff16) : 16'd0;
    mtu_word  = (up_data.op == icmp_ht_pkg::DIR_V4_TO_V6) ?
                {15'd0, mtu_up} : {16'd0, mtu_dn};
    unique case (up_data.rest_sel)
      icmp_ht_pkg::REST_COPY: rest = up_data.rest_word;
      icmp_ht_pkg::REST_ZERO: rest = 32'd0;
      icmp_ht_pkg::REST_PTR:  rest = {24'd0, icmp_ht_pkg::PTR_NEXT_HDR};
      icmp_ht_pkg::REST_MTU:  rest = mtu_word;
      default:                rest = 32'd0;
    endcase
    if (up_data.drop) begin
      out_nxt      = '0;
      out_nxt.drop = 1'b1;
    end else begin
      out_nxt.drop               = 1'b0;
      out_nxt.out_type           = up_data.out_type;
      out_nxt.out_code           = up_data.out_code;
      out_nxt.out_rest_word      = rest;
      out_nxt.is_error           = up_data.is_error;
      out_nxt.quoted_payload_len = up_data.is_error ? up_data.quote_len : 11'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/icmp_header_translator_core.sv */
// ----------------------------------------------------------------------------
// icmp_header_translator_core
// Stateless ICMP/ICMPv6 header translator, three-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one ICMP header per clock while in_stall is low and returns the
// translations in order, one result per header, through three register
// stages: classify (type/code map, length checks, plateau estimate),
// resolve (MTU source, quote truncation) and emit (MTU clamp and
// header-size adjust, rest word, drop zeroing). Each stage holds its item
// while the next one is full, so throughput stays at one header per cycle
// whenever out_stall is low; in_stall rises only when all three stages
// hold items and the output is stalled. Write cfg_* only while the pipeline
// is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_header_translator_core (
  input  wire         clk,
  input  wire         rst_n,

  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_wdata,

  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_op,
  input  wire  [7:0]  in_msg_type,
  input  wire  [7:0]  in_msg_code,
  input  wire  [31:0] in_rest_word,
  input  wire  [15:0] in_outer_total_len,
  input  wire  [15:0] in_body_len,
  input  wire  [3:0]  in_inner_ihl,
  input  wire  [7:0]  in_inner_next_header,

  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_drop,
  output logic [7:0]  out_out_type,
  output logic [7:0]  out_out_code,
  output logic [31:0] out_out_rest_word,
  output logic        out_is_error,
  output logic [10:0] out_quoted_payload_len
);

  icmp_ht_pkg::cfg_t     cfg_r;
  icmp_ht_pkg::hdr_in_t  hdr_in;
  icmp_ht_pkg::cls_t     cls;
  icmp_ht_pkg::res_t     res;
  icmp_ht_pkg::hdr_out_t hdr_out;
  logic                  s1_ready;
  logic                  s1_valid;
  logic                  s2_ready;
  logic                  s2_valid;
  logic                  s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tunnel_mtu       <= icmp_ht_pkg::RST_TUNNEL_MTU;
      cfg_r.header_size_diff <= icmp_ht_pkg::RST_HDR_DIFF;
      cfg_r.min_mtu_v4       <= icmp_ht_pkg::RST_MIN_MTU_V4;
      cfg_r.min_mtu_v6       <= icmp_ht_pkg::RST_MIN_MTU_V6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icmp_ht_pkg::CFG_TUNNEL_MTU: cfg_r.tunnel_mtu       <= cfg_wdata;
        icmp_ht_pkg::CFG_HDR_DIFF:   cfg_r.header_size_diff <= cfg_wdata[7:0];
        icmp_ht_pkg::CFG_MIN_MTU_V4: cfg_r.min_mtu_v4       <= cfg_wdata;
        icmp_ht_pkg::CFG_MIN_MTU_V6: cfg_r.min_mtu_v6       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign hdr_in.op                = in_op;
  assign hdr_in.msg_type          = in_msg_type;
  assign hdr_in.msg_code          = in_msg_code;
  assign hdr_in.rest_word         = in_rest_word;
  assign hdr_in.outer_total_len   = in_outer_total_len;
  assign hdr_in.body_len          = in_body_len;
  assign hdr_in.inner_ihl         = in_inner_ihl;
  assign hdr_in.inner_next_header = in_inner_next_header;

  assign in_stall = !s1_ready;

  icmp_ht_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (s1_ready),
    .up_data  (hdr_in),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_data  (cls)
  );

  icmp_ht_resolve u_resolve (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (cls),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_data  (res)
  );

  icmp_ht_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .up_data  (res),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_data  (hdr_out)
  );

  assign out_drop               = hdr_out.drop;
  assign out_out_type           = hdr_out.out_type;
  assign out_out_code           = hdr_out.out_code;
  assign out_out_rest_word      = hdr_out.out_rest_word;
  assign out_is_error           = hdr_out.is_error;
  assign out_quoted_payload_len = hdr_out.quoted_payload_len;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
    else $error("input stalled while pipeline has room");

  a_drop_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drop) |-> (out_out_type == 8'd0 && out_out_code == 8'd0 &&
      out_out_rest_word == 32'd0 && !out_is_error && out_quoted_payload_len == 11'd0))
    else $error("dropped result carries nonzero fields");

  a_quote_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quoted_payload_len <= icmp_ht_pkg::QUOTE6_MAX[10:0]))
    else $error("quoted payload length above limit");

  a_echo_no_quote: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_error) |-> (out_quoted_payload_len == 11'd0))
    else $error("echo result with quoted payload length");

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for icmp_header_translator_core.
// ----------------------------------------------------------------------------
// Sends ICMP and ICMPv6 headers through the valid/stall input channel and
// predicts the translation of each accepted header. A checker compares every
// result transfer with the oldest prediction, one field at a time. Directed
// headers cover the echo copies, the type and code maps, the MTU paths and
// the length limits. Random headers, mostly well formed, then run under
// several register settings that include the extreme values. Both sides
// insert random gaps and stalls, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb;
  import icmp_ht_pkg::*;

  localparam int PIPE_DEPTH = 3;
  localparam logic [7:0] ICMP4_PARAM_PROB = 8'd12;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [7:0]  in_msg_type;
  logic [7:0]  in_msg_code;
  logic [31:0] in_rest_word;
  logic [15:0] in_outer_total_len;
  logic [15:0] in_body_len;
  logic [3:0]  in_inner_ihl;
  logic [7:0]  in_inner_next_header;
  logic        out_valid;
  logic        out_stall;
  logic        out_drop;
  logic [7:0]  out_out_type;
  logic [7:0]  out_out_code;
  logic [31:0] out_out_rest_word;
  logic        out_is_error;
  logic [10:0] out_quoted_payload_len;

  cfg_t        cur_cfg;
  hdr_out_t    pending_xlat[$];
  int unsigned err_cnt = 0;
  bit          in_gaps_on = 1'b1;
  bit          out_stalls_on = 1'b1;

  icmp_header_translator_core i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_op                  (in_op),
    .in_msg_type            (in_msg_type),
    .in_msg_code            (in_msg_code),
    .in_rest_word           (in_rest_word),
    .in_outer_total_len     (in_outer_total_len),
    .in_body_len            (in_body_len),
    .in_inner_ihl           (in_inner_ihl),
    .in_inner_next_header   (in_inner_next_header),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_drop               (out_drop),
    .out_out_type           (out_out_type),
    .out_out_code           (out_out_code),
    .out_out_rest_word      (out_out_rest_word),
    .out_is_error           (out_is_error),
    .out_quoted_payload_len (out_quoted_payload_len)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[icmp_header_translator_core] ERROR");
    $finish;
  end

  function automatic logic [15:0] plateau_mtu(input logic [15:0] len);
    logic [15:0] est;
    if (len > 16'd32000) est = 16'd32000;
    else if (len > 16'd17914) est = 16'd17914;
    else if (len > 16'd8166) est = 16'd8166;
    else if (len > 16'd4352) est = 16'd4352;
    else if (len > 16'd2002) est = 16'd2002;
    else if (len > 16'd1492) est = 16'd1492;
    else if (len > 16'd1006) est = 16'd1006;
    else if (len > 16'd508) est = 16'd508;
    else if (len > 16'd296) est = 16'd296;
    else est = cur_cfg.min_mtu_v4;
    return est;
  endfunction

  function automatic hdr_out_t translate_hdr(input hdr_in_t h);
    hdr_out_t    r;
    logic [31:0] mtu;
    logic [15:0] quote;
    logic        ok;
    logic        echo;
    r = '0;
    ok = 1'b1;
    echo = 1'b0;
    mtu = '0;
    quote = '0;
    if (h.op == DIR_V4_TO_V6) begin
      if (h.msg_type == ICMP4_ECHO_REPLY || h.msg_type == ICMP4_ECHO_REQ) begin
        echo = 1'b1;
        r.out_type = (h.msg_type == ICMP4_ECHO_REPLY) ? ICMP6_ECHO_RSP : ICMP6_ECHO_REQ;
        r.out_rest_word = h.rest_word;
      end else if (h.body_len < V4_MIN_ERR_LEN) begin
        ok = 1'b0;
      end else if (h.msg_type == ICMP4_DEST_UNREACH) begin
        r.out_type = ICMP6_DEST_UNREACH;
        case (h.msg_code)
          UNR4_NET, UNR4_HOST, UNR4_SRC_ROUTE, UNR4_NET_UNKNOWN, UNR4_HOST_UNKNOWN,
          UNR4_SRC_ISOLATED, UNR4_NET_TOS, UNR4_HOST_TOS: r.out_code = UNR6_NO_ROUTE;
          UNR4_PROTO: begin
            r.out_type = ICMP6_BAD_PARAM;
            r.out_code = PARAM6_NEXT_HDR;
            r.out_rest_word = {24'h0, PTR_NEXT_HDR};
          end
          UNR4_PORT: r.out_code = UNR6_PORT;
          UNR4_FRAG_NEEDED: begin
            r.out_type = ICMP6_PKT_TOO_BIG;
            r.out_code = CODE_ZERO;
            mtu = {16'h0, h.rest_word[15:0]};
            if (mtu < cur_cfg.min_mtu_v4) mtu = {16'h0, plateau_mtu(h.outer_total_len)};
            if (mtu < cur_cfg.min_mtu_v6) mtu = {16'h0, cur_cfg.min_mtu_v6};
            r.out_rest_word = mtu + cur_cfg.header_size_diff;
          end
          UNR4_NET_PROHIB, UNR4_HOST_PROHIB, UNR4_ADMIN_PROHIB, UNR4_PREC_CUTOFF:
            r.out_code = UNR6_ADMIN_PROHIB;
          default: ok = 1'b0;
        endcase
      end else if (h.msg_type == ICMP4_TIME_EXCEED) begin
        r.out_type = ICMP6_TIME_EXCEED;
        r.out_code = h.msg_code;
      end else begin
        ok = 1'b0;
      end
      if (!echo && ok && {h.inner_ihl, 2'b00} > h.body_len) ok = 1'b0;
      quote = h.body_len - {h.inner_ihl, 2'b00};
      if (quote > QUOTE6_MAX) quote = QUOTE6_MAX;
    end else begin
      if (h.msg_type == ICMP6_ECHO_REQ || h.msg_type == ICMP6_ECHO_RSP) begin
        echo = 1'b1;
        r.out_type = (h.msg_type == ICMP6_ECHO_REQ) ? ICMP4_ECHO_REQ : ICMP4_ECHO_REPLY;
        r.out_rest_word = h.rest_word;
      end else if (h.body_len < V6_HDR_LEN) begin
        ok = 1'b0;
      end else begin
        case (h.msg_type)
          ICMP6_DEST_UNREACH: begin
            r.out_type = ICMP4_DEST_UNREACH;
            case (h.msg_code)
              UNR6_NO_ROUTE, UNR6_BEYOND_SCOPE: r.out_code = UNR4_HOST;
              UNR6_ADMIN_PROHIB: r.out_code = UNR4_HOST_PROHIB;
              UNR6_PORT: r.out_code = UNR4_PORT;
              default: ok = 1'b0;
            endcase
          end
          ICMP6_PKT_TOO_BIG: begin
            mtu = h.rest_word;
            if (mtu > cur_cfg.tunnel_mtu) mtu = {16'h0, cur_cfg.tunnel_mtu};
            mtu = (mtu > cur_cfg.header_size_diff) ? mtu - cur_cfg.header_size_diff : '0;
            r.out_type = ICMP4_DEST_UNREACH;
            r.out_code = UNR4_FRAG_NEEDED;
            r.out_rest_word = {16'h0, mtu[15:0]};
          end
          ICMP6_TIME_EXCEED: begin
            r.out_type = ICMP4_TIME_EXCEED;
            r.out_code = h.msg_code;
          end
          ICMP6_BAD_PARAM: begin
            if (h.msg_code != PARAM6_NEXT_HDR) ok = 1'b0;
            r.out_type = ICMP4_DEST_UNREACH;
            r.out_code = UNR4_PROTO;
          end
          default: ok = 1'b0;
        endcase
      end
      quote = h.body_len - V6_HDR_LEN;
      if (quote > QUOTE4_MAX) quote = QUOTE4_MAX;
      if (!echo && h.inner_next_header == NH_FRAGMENT) begin
        if (quote < FRAG_HDR_LEN) ok = 1'b0;
        else quote = quote - FRAG_HDR_LEN;
      end
    end
    if (!ok) begin
      r = '0;
      r.drop = 1'b1;
    end else if (!echo) begin
      r.is_error = 1'b1;
      r.quoted_payload_len = quote[10:0];
    end
    return r;
  endfunction

  function automatic hdr_in_t hdr_of(input logic op, input logic [7:0] ty,
                                     input logic [7:0] code, input logic [31:0] rest,
                                     input logic [15:0] tot, input logic [15:0] dlen,
                                     input logic [3:0] ihl, input logic [7:0] nh);
    hdr_in_t h;
    h.op = op;
    h.msg_type = ty;
    h.msg_code = code;
    h.rest_word = rest;
    h.outer_total_len = tot;
    h.body_len = dlen;
    h.inner_ihl = ihl;
    h.inner_next_header = nh;
    return h;
  endfunction

  function automatic hdr_in_t rand_hdr();
    hdr_in_t h;
    int      kind;
    int      pick;
    h.op = 1'($urandom_range(0, 1));
    h.rest_word = $urandom;
    h.outer_total_len = 16'($urandom_range(0, (1 << $urandom_range(8, 16)) - 1));
    h.inner_ihl = 4'($urandom);
    h.inner_next_header = ($urandom_range(0, 1) == 0) ? NH_FRAGMENT : 8'($urandom);
    h.msg_code = 8'($urandom);
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (kind < 12) begin
      h.msg_type = 8'($urandom);
      h.body_len = 16'($urandom);
    end else begin
      if (kind < 30) h.body_len = 16'($urandom_range(12, 70));
      else if (kind < 40) h.body_len = 16'($urandom);
      else h.body_len = 16'($urandom_range(40, 1400));
      if (h.op == DIR_V4_TO_V6) begin
        if ($urandom_range(0, 1) == 0) h.rest_word[15:0] = 16'($urandom_range(0, 400));
        case (pick)
          0: h.msg_type = ICMP4_ECHO_REPLY;
          1: h.msg_type = ICMP4_ECHO_REQ;
          2, 3, 4, 5, 6: begin
            h.msg_type = ICMP4_DEST_UNREACH;
            if ($urandom_range(0, 3) == 0) h.msg_code = UNR4_FRAG_NEEDED;
            else if ($urandom_range(0, 7) != 0) h.msg_code = 8'($urandom_range(0, 15));
          end
          7, 8: begin
            h.msg_type = ICMP4_TIME_EXCEED;
            if ($urandom_range(0, 1) == 0) h.msg_code = 8'($urandom_range(0, 1));
          end
          default: h.msg_type = 8'($urandom);
        endcase
      end else begin
        if (kind < 30) h.body_len = 16'($urandom_range(30, 56));
        case (pick)
          0: h.msg_type = ICMP6_ECHO_REQ;
          1: h.msg_type = ICMP6_ECHO_RSP;
          2, 3: begin
            h.msg_type = ICMP6_DEST_UNREACH;
            h.msg_code = 8'($urandom_range(0, 5));
          end
          4, 5: begin
            h.msg_type = ICMP6_PKT_TOO_BIG;
            case ($urandom_range(0, 2))
              0: h.rest_word = $urandom_range(0, 400);
              1: h.rest_word = $urandom_range(1200, 70000);
              default: h.rest_word = $urandom;
            endcase
          end
          6, 7: begin
            h.msg_type = ICMP6_TIME_EXCEED;
            if ($urandom_range(0, 1) == 0) h.msg_code = 8'($urandom_range(0, 1));
          end
          8: begin
            h.msg_type = ICMP6_BAD_PARAM;
            h.msg_code = 8'($urandom_range(0, 2));
          end
          default: h.msg_type = 8'($urandom);
        endcase
      end
    end
    return h;
  endfunction

  task automatic send_hdr(input hdr_in_t h);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= h.op;
    in_msg_type <= h.msg_type;
    in_msg_code <= h.msg_code;
    in_rest_word <= h.rest_word;
    in_outer_total_len <= h.outer_total_len;
    in_body_len <= h.body_len;
    in_inner_ihl <= h.inner_ihl;
    in_inner_next_header <= h.inner_next_header;
    do @(posedge clk); while (in_stall);
    pending_xlat.push_back(translate_hdr(h));
  endtask

  task automatic settle_pipe();
    in_valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [15:0] tmtu, input logic [7:0] diff,
                           input logic [15:0] v4min, input logic [15:0] v6min);
    settle_pipe();
    cfg_we <= 1'b1;
    cfg_index <= CFG_TUNNEL_MTU;
    cfg_wdata <= tmtu;
    @(posedge clk);
    cfg_index <= CFG_HDR_DIFF;
    cfg_wdata <= {8'h00, diff};
    @(posedge clk);
    cfg_index <= CFG_MIN_MTU_V4;
    cfg_wdata <= v4min;
    @(posedge clk);
    cfg_index <= CFG_MIN_MTU_V6;
    cfg_wdata <= v6min;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cfg.tunnel_mtu = tmtu;
    cur_cfg.header_size_diff = diff;
    cur_cfg.min_mtu_v4 = v4min;
    cur_cfg.min_mtu_v6 = v6min;
  endtask

  task automatic test_echo();
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_ECHO_REPLY, 8'h5A, 32'hFFFF_FFFF, 16'hFFFF, 16'd0,
                    4'd0, 8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_ECHO_REQ, 8'h00, 32'h0000_0000, 16'd0, 16'd0,
                    4'hF, 8'hFF));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_ECHO_REQ, 8'h00, 32'hDEAD_BEEF, 16'd0, 16'd0,
                    4'd0, NH_FRAGMENT));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_ECHO_RSP, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF,
                    16'hFFFF, 4'hF, 8'hFF));
  endtask

  task automatic test_type_map();
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_DEST_UNREACH, UNR4_NET, 32'h1234_5678, 16'd100,
                    16'd64, 4'd5, 8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_DEST_UNREACH, UNR4_PROTO, 32'h0, 16'd100, 16'd64,
                    4'd5, 8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_DEST_UNREACH, UNR4_PORT, 32'h0, 16'd100, 16'd64,
                    4'd5, 8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_DEST_UNREACH, UNR4_NET_PROHIB, 32'h0, 16'd100,
                    16'd64, 4'd5, 8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_DEST_UNREACH, 8'd14, 32'h0, 16'd100, 16'd64,
                    4'd5, 8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_TIME_EXCEED, 8'd1, 32'hFFFF_FFFF, 16'd100,
                    16'hFFFF, 4'hF, 8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_PARAM_PROB, 8'd0, 32'h0, 16'd100, 16'd64,
                    4'd5, 8'd0));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_DEST_UNREACH, UNR6_ADMIN_PROHIB, 32'h0, 16'd0,
                    16'd100, 4'd0, 8'd17));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_DEST_UNREACH, UNR6_ADDR, 32'h0, 16'd0, 16'd100,
                    4'd0, 8'd17));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_TIME_EXCEED, 8'hFF, 32'h0, 16'd0, 16'd100,
                    4'd0, 8'd17));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_BAD_PARAM, PARAM6_NEXT_HDR, 32'h0, 16'd0,
                    16'd100, 4'd0, 8'd17));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_BAD_PARAM, CODE_ZERO, 32'h0, 16'd0, 16'd100,
                    4'd0, 8'd17));
  endtask

  task automatic test_mtu_paths();
    // upper half of the rest word carries no MTU
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_DEST_UNREACH, UNR4_FRAG_NEEDED, 32'hFFFF_05DC,
                    16'd100, 16'd64, 4'd5, 8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_DEST_UNREACH, UNR4_FRAG_NEEDED, 32'h0, 16'd1500,
                    16'd64, 4'd5, 8'd0));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_PKT_TOO_BIG, CODE_ZERO, 32'h0001_0000, 16'd0,
                    16'd100, 4'd0, 8'd17));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_PKT_TOO_BIG, CODE_ZERO, 32'd10, 16'd0, 16'd100,
                    4'd0, 8'd17));
  endtask

  task automatic test_length_limits();
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_TIME_EXCEED, 8'd0, 32'h0, 16'd0, 16'd19, 4'd0,
                    8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_TIME_EXCEED, 8'd0, 32'h0, 16'd0, 16'd20, 4'd6,
                    8'd0));
    send_hdr(hdr_of(DIR_V4_TO_V6, ICMP4_TIME_EXCEED, 8'd0, 32'h0, 16'd0, 16'd20, 4'd0,
                    8'd0));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_TIME_EXCEED, 8'd0, 32'h0, 16'd0, 16'd39, 4'd0,
                    8'd0));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_TIME_EXCEED, 8'd0, 32'h0, 16'd0, 16'd47, 4'd0,
                    NH_FRAGMENT));
    send_hdr(hdr_of(DIR_V6_TO_V4, ICMP6_TIME_EXCEED, 8'd0, 32'h0, 16'd0, 16'd48, 4'd0,
                    NH_FRAGMENT));
  endtask

  task automatic test_random_traffic(input int n_hdrs);
    logic [1:0] mode;
    for (int i = 0; i < n_hdrs; i++) begin
      if (i % 60 == 0) begin
        mode = 2'($urandom_range(0, 3));
        in_gaps_on = mode[0];
        out_stalls_on = mode[1];
      end
      send_hdr(rand_hdr());
    end
  endtask

  task automatic test_cfg_sweep();
    apply_cfg(16'd65535, 8'd255, 16'd65535, 16'd0);
    test_random_traffic(180);
    apply_cfg(16'd1280, 8'd0, 16'd0, 16'd65535);
    test_random_traffic(180);
    apply_cfg(16'($urandom_range(1280, 9000)), 8'($urandom), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 1500)));
    test_random_traffic(180);
    apply_cfg(16'd1280, 8'd255, 16'd1500, 16'd1280);
    test_random_traffic(180);
  endtask

  initial begin : out_stall_gen
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = out_stalls_on ? $urandom_range(0, 5) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    hdr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_xlat.size() == 0) begin
        $error("result transfer with no header pending");
        err_cnt++;
      end else begin
        want = pending_xlat.pop_front();
        if (out_drop !== want.drop) begin
          $error("drop: expected %0d, got %0d", want.drop, out_drop);
          err_cnt++;
        end
        if (out_out_type !== want.out_type) begin
          $error("out_type: expected %0d, got %0d", want.out_type, out_out_type);
          err_cnt++;
        end
        if (out_out_code !== want.out_code) begin
          $error("out_code: expected %0d, got %0d", want.out_code, out_out_code);
          err_cnt++;
        end
        if (out_out_rest_word !== want.out_rest_word) begin
          $error("out_rest_word: expected 0x%08h, got 0x%08h", want.out_rest_word,
                 out_out_rest_word);
          err_cnt++;
        end
        if (out_is_error !== want.is_error) begin
          $error("is_error: expected %0d, got %0d", want.is_error, out_is_error);
          err_cnt++;
        end
        if (out_quoted_payload_len !== want.quoted_payload_len) begin
          $error("quoted_payload_len: expected %0d, got %0d", want.quoted_payload_len,
                 out_quoted_payload_len);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TUNNEL_MTU;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_op <= DIR_V4_TO_V6;
    in_msg_type <= '0;
    in_msg_code <= '0;
    in_rest_word <= '0;
    in_outer_total_len <= '0;
    in_body_len <= '0;
    in_inner_ihl <= '0;
    in_inner_next_header <= '0;
    cur_cfg.tunnel_mtu = RST_TUNNEL_MTU;
    cur_cfg.header_size_diff = RST_HDR_DIFF;
    cur_cfg.min_mtu_v4 = RST_MIN_MTU_V4;
    cur_cfg.min_mtu_v6 = RST_MIN_MTU_V6;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_echo();
    test_type_map();
    test_mtu_paths();
    test_length_limits();
    test_random_traffic(180);
    test_cfg_sweep();

    settle_pipe();
    if (err_cnt == 0) begin
      $display("[icmp_header_translator_core] OK");
    end else begin
      $display("[icmp_header_translator_core] ERROR");
    end
    $finish;
  end

endmodule
